/* src/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks sampled on clk, held off while rst_n is low.
`define PVSR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define PVSR_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

/* src/pvsr_pkg.sv */
package pvsr_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int MAG_BITS_DEF     = 16;
  localparam int ATAN_DEPTH       = 24;
  localparam int ROOT_ITERS       = 32;
  localparam int CNT_W            = 5;
  localparam int Z_W              = 34;
  localparam int ROOT_W           = 64;
  localparam int PRE_W            = 46;

  // CORDIC gain compensation, 1/K in Q30
  localparam logic [29:0] GAIN_Q30 = 30'd652032874;

  // atan(2^-i) in 2^32-per-turn units
  localparam logic [31:0] ATAN_TURNS [ATAN_DEPTH] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // CORDIC x/y width: rotation needs MAG_BITS + 10, vectoring of the sums needs 36
  function automatic int cord_width(int mag_bits);
    return (mag_bits + 10 > 36) ? mag_bits + 10 : 36;
  endfunction

  typedef struct packed {
    logic [15:0] force_magnitude;
    logic [15:0] force_angle;
    logic        last_force;
  } in_t;

  typedef struct packed {
    logic signed [31:0] total_x;
    logic signed [31:0] total_y;
    logic [31:0]        resultant_magnitude;
    logic signed [15:0] resultant_angle;
    logic               sum_overflow;
  } out_t;

  typedef enum logic [1:0] {
    CORD_NOP,
    CORD_ROT_LOAD,
    CORD_VEC_LOAD,
    CORD_ITER
  } cord_op_t;

  typedef enum logic [2:0] {
    ROOT_NOP,
    ROOT_LOAD,
    ROOT_ADD,
    ROOT_ITER,
    ROOT_FIN
  } root_op_t;

  typedef enum logic [1:0] {
    MUL_NOP,
    MUL_SQ_X,
    MUL_SQ_Y
  } mul_op_t;

  typedef struct packed {
    cord_op_t         cord_op;
    root_op_t         root_op;
    mul_op_t          mul_op;
    logic             take_in;
    logic             accum;
    logic             emit;
    logic [CNT_W-1:0] iter;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic last;
    logic out_busy;
  } stat_t;

endpackage

/* src/pvsr_useq.sv */
module pvsr_useq #(
  parameter int CORDIC_STEPS = pvsr_pkg::CORDIC_STEPS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  pvsr_pkg::stat_t stat,
  output pvsr_pkg::ctrl_t ctrl
);
  import pvsr_pkg::*;

  localparam int UPC_W = 4;

  typedef logic [UPC_W-1:0] upc_t;

  typedef enum logic [2:0] {
    JMP_NONE,
    JMP_ALWAYS,
    JMP_NO_ACCEPT,
    JMP_CORD_LOOP,
    JMP_ROOT_LOOP,
    JMP_NOT_LAST,
    JMP_OUT_BUSY
  } jump_t;

  typedef struct packed {
    cord_op_t cord_op;
    root_op_t root_op;
    mul_op_t  mul_op;
    logic     take_in;
    logic     accum;
    logic     emit;
    jump_t    jump;
    upc_t     target;
  } uword_t;

  localparam upc_t U_WAIT      = 4'd0;
  localparam upc_t U_ROT_LOAD  = 4'd1;
  localparam upc_t U_ROT_ITER  = 4'd2;
  localparam upc_t U_ACCUM     = 4'd3;
  localparam upc_t U_SQ_X      = 4'd4;
  localparam upc_t U_SQ_Y      = 4'd5;
  localparam upc_t U_SQ_SUM    = 4'd6;
  localparam upc_t U_VEC_ITER  = 4'd7;
  localparam upc_t U_ROOT_ITER = 4'd8;
  localparam upc_t U_ROOT_FIN  = 4'd9;
  localparam upc_t U_OUT_WAIT  = 4'd10;
  localparam upc_t U_EMIT      = 4'd11;

  function automatic uword_t ucode(upc_t addr);
    uword_t w;
    w = '{cord_op: CORD_NOP, root_op: ROOT_NOP, mul_op: MUL_NOP, take_in: 1'b0,
          accum: 1'b0, emit: 1'b0, jump: JMP_NONE, target: U_WAIT};
    unique case (addr)
      U_WAIT: begin
        w.take_in = 1'b1;
        w.jump    = JMP_NO_ACCEPT;
        w.target  = U_WAIT;
      end
      U_ROT_LOAD: w.cord_op = CORD_ROT_LOAD;
      U_ROT_ITER: begin
        w.cord_op = CORD_ITER;
        w.jump    = JMP_CORD_LOOP;
        w.target  = U_ROT_ITER;
      end
      U_ACCUM: begin
        w.accum  = 1'b1;
        w.jump   = JMP_NOT_LAST;
        w.target = U_WAIT;
      end
      U_SQ_X: begin
        w.mul_op  = MUL_SQ_X;
        w.cord_op = CORD_VEC_LOAD;
      end
      U_SQ_Y: begin
        w.mul_op  = MUL_SQ_Y;
        w.root_op = ROOT_LOAD;
      end
      U_SQ_SUM: w.root_op = ROOT_ADD;
      U_VEC_ITER: begin
        w.cord_op = CORD_ITER;
        w.jump    = JMP_CORD_LOOP;
        w.target  = U_VEC_ITER;
      end
      U_ROOT_ITER: begin
        w.root_op = ROOT_ITER;
        w.jump    = JMP_ROOT_LOOP;
        w.target  = U_ROOT_ITER;
      end
      U_ROOT_FIN: w.root_op = ROOT_FIN;
      U_OUT_WAIT: begin
        w.jump   = JMP_OUT_BUSY;
        w.target = U_OUT_WAIT;
      end
      U_EMIT: begin
        w.emit   = 1'b1;
        w.jump   = JMP_ALWAYS;
        w.target = U_WAIT;
      end
      default: begin
        w.jump   = JMP_ALWAYS;
        w.target = U_WAIT;
      end
    endcase
    return w;
  endfunction

  upc_t             upc_r, upc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  uword_t           uw;
  logic             taken;
  logic             looping;

  always_comb begin
    uw = ucode(upc_r);
    unique case (uw.jump)
      JMP_NONE:      taken = 1'b0;
      JMP_ALWAYS:    taken = 1'b1;
      JMP_NO_ACCEPT: taken = !stat.in_valid;
      JMP_CORD_LOOP: taken = (cnt_r != CNT_W'(CORDIC_STEPS - 1));
      JMP_ROOT_LOOP: taken = (cnt_r != CNT_W'(ROOT_ITERS - 1));
      JMP_NOT_LAST:  taken = !stat.last;
      JMP_OUT_BUSY:  taken = stat.out_busy;
      default:       taken = 1'b0;
    endcase
    // loop counter runs only while a loop word jumps back, so each loop starts at 0
    looping = taken && (uw.jump == JMP_CORD_LOOP || uw.jump == JMP_ROOT_LOOP);
    upc_nxt = taken ? uw.target : upc_r + 1'b1;
    cnt_nxt = looping ? cnt_r + 1'b1 : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= U_WAIT;
      cnt_r <= '0;
    end else begin
      upc_r <= upc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_comb begin
    ctrl.cord_op = uw.cord_op;
    ctrl.root_op = uw.root_op;
    ctrl.mul_op  = uw.mul_op;
    ctrl.take_in = uw.take_in;
    ctrl.accum   = uw.accum;
    ctrl.emit    = uw.emit;
    ctrl.iter    = cnt_r;
  end

endmodule

/* src/pvsr_cordic.sv */
module pvsr_cordic #(
  parameter int  MAG_BITS = pvsr_pkg::MAG_BITS_DEF,
  localparam int CW       = pvsr_pkg::cord_width(MAG_BITS)
) (
  input  logic                       clk,
  input  pvsr_pkg::ctrl_t            ctrl,
  input  logic [pvsr_pkg::PRE_W-1:0] pre_prod,
  input  logic [15:0]                angle_in,
  input  logic signed [31:0]         vec_x,
  input  logic signed [31:0]         vec_y,
  output logic signed [CW-1:0]       rot_x,
  output logic signed [CW-1:0]       rot_y,
  output logic signed [15:0]         vec_angle
);
  import pvsr_pkg::*;

  localparam int SH = 38 - MAG_BITS;
  localparam int QS = MAG_BITS - 8;
  localparam logic [PRE_W-1:0] PRE_RND = PRE_W'(1) << (37 - MAG_BITS);

  logic signed [CW-1:0]  x_r, x_nxt, y_r, y_nxt;
  logic signed [Z_W-1:0] z_r, z_nxt;
  logic                  vec_mode_r, vec_mode_nxt;
  logic                  zero_r, zero_nxt;
  logic [PRE_W-1:0]      pre_rnd;
  logic [CW-1:0]         x_mag;
  logic signed [CW-1:0]  vx, vy, dx, dy;
  logic signed [Z_W-1:0] at;
  logic                  fold;
  logic                  sigma;
  logic [31:0]           z_rnd;

  always_comb begin
    pre_rnd = pre_prod + PRE_RND;
    x_mag   = CW'(pre_rnd >> SH);
    // second and third quadrant: rotate by half a turn, start from -x
    fold    = angle_in[15] ^ angle_in[14];
    vx      = CW'(vec_x);
    vy      = CW'(vec_y);
    dx      = y_r >>> ctrl.iter;
    dy      = x_r >>> ctrl.iter;
    if (ctrl.iter < CNT_W'(ATAN_DEPTH)) begin
      at = signed'(Z_W'(ATAN_TURNS[ctrl.iter]));
    end else begin
      at = '0;
    end
    sigma = vec_mode_r ? y_r[CW-1] : !z_r[Z_W-1];

    x_nxt        = x_r;
    y_nxt        = y_r;
    z_nxt        = z_r;
    vec_mode_nxt = vec_mode_r;
    zero_nxt     = zero_r;
    unique case (ctrl.cord_op)
      CORD_NOP: ;
      CORD_ROT_LOAD: begin
        x_nxt        = fold ? -signed'(x_mag) : signed'(x_mag);
        y_nxt        = '0;
        z_nxt        = {{(Z_W - 32){angle_in[14]}}, angle_in[14], angle_in[14:0], 16'h0000};
        vec_mode_nxt = 1'b0;
      end
      CORD_VEC_LOAD: begin
        if (vec_x[31]) begin
          x_nxt = -vx;
          y_nxt = -vy;
          z_nxt = signed'(Z_W'(32'h8000_0000));
        end else begin
          x_nxt = vx;
          y_nxt = vy;
          z_nxt = '0;
        end
        zero_nxt     = (vec_x == '0) && (vec_y == '0);
        vec_mode_nxt = 1'b1;
      end
      CORD_ITER: begin
        if (sigma) begin
          x_nxt = x_r - dx;
          y_nxt = y_r + dy;
          z_nxt = z_r - at;
        end else begin
          x_nxt = x_r + dx;
          y_nxt = y_r - dy;
          z_nxt = z_r + at;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    z_r        <= z_nxt;
    vec_mode_r <= vec_mode_nxt;
    zero_r     <= zero_nxt;
  end

  // round to Q8.8, half up, floor shift
  if (QS == 0) begin : g_q_plain
    assign rot_x = x_r;
    assign rot_y = y_r;
  end else begin : g_q_round
    localparam logic signed [CW-1:0] QRND = signed'(CW'(1) << (QS - 1));
    assign rot_x = (x_r + QRND) >>> QS;
    assign rot_y = (y_r + QRND) >>> QS;
  end

  assign z_rnd     = z_r[31:0] + 32'h0000_8000;
  assign vec_angle = zero_r ? '0 : signed'(z_rnd[31:16]);

endmodule

/* src/pvsr_root.sv */
module pvsr_root (
  input  logic                        clk,
  input  pvsr_pkg::ctrl_t             ctrl,
  input  logic [pvsr_pkg::ROOT_W-1:0] din,
  output logic [31:0]                 root
);
  import pvsr_pkg::*;

  localparam logic [ROOT_W-1:0] BIT_TOP = ROOT_W'(1) << (ROOT_W - 2);

  logic [ROOT_W-1:0] n_r, n_nxt, res_r, res_nxt, bit_r, bit_nxt;
  logic [ROOT_W-1:0] trial;

  // bit-pair restoring square root, one result bit per step
  always_comb begin
    trial   = res_r + bit_r;
    n_nxt   = n_r;
    res_nxt = res_r;
    bit_nxt = bit_r;
    unique case (ctrl.root_op)
      ROOT_NOP: ;
      ROOT_LOAD: n_nxt = din;
      ROOT_ADD: begin
        n_nxt   = n_r + din;
        res_nxt = '0;
        bit_nxt = BIT_TOP;
      end
      ROOT_ITER: begin
        if (n_r >= trial) begin
          n_nxt   = n_r - trial;
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
      end
      ROOT_FIN: begin
        // round to nearest; remainder above root means the half is passed
        if (n_r > res_r) begin
          res_nxt = res_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign root = res_r[31:0];

endmodule

/* src/polar_vector_sum_resultant.sv */
// Channel  Ports                              Word
// in       in_valid, in_ready, in_data        one polar vector: magnitude, angle, last flag
// out      out_valid, out_ready, out_data     sums, resultant length and direction, overflow
//
// A word without the last flag passes through the rotation loop of the shared CORDIC
// unit. A last word passes through rotation, vectoring of the sums, then 32 steps of
// the square root unit.
// Reset is synchronous; in_ready rises on the first cycle after rst_n goes high.
// The result sits in the output register until taken; later words are accepted meanwhile
// and only the next result waits for out_ready.
module polar_vector_sum_resultant #(
  parameter int CORDIC_STEPS = pvsr_pkg::CORDIC_STEPS_DEF,
  parameter int MAG_BITS     = pvsr_pkg::MAG_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  pvsr_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output pvsr_pkg::out_t out_data
);
  import pvsr_pkg::*;

  localparam int CW    = cord_width(MAG_BITS);
  localparam int SUM_W = CW + 1;
  localparam logic signed [SUM_W-1:0] SAT_HI = {{(SUM_W - 31){1'b0}}, {31{1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO = {{(SUM_W - 31){1'b1}}, 31'd0};

  ctrl_t                ctrl;
  stat_t                stat;
  logic                 accept;
  logic                 out_busy;
  logic                 emit_fire;
  logic [PRE_W-1:0]     pre_r;
  logic [15:0]          ang_r;
  logic                 last_r;
  logic signed [31:0]   acc_x_r, acc_x_nxt, acc_y_r, acc_y_nxt;
  logic                 ovf_r, ovf_nxt;
  logic signed [CW-1:0] rot_x, rot_y;
  logic signed [15:0]   vec_angle;
  logic [31:0]          root;
  logic signed [SUM_W-1:0] sum_x, sum_y;
  logic signed [31:0]   mul_src;
  logic signed [63:0]   sq;
  logic [ROOT_W-1:0]    mul_r;
  out_t                 out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;

  pvsr_useq #(.CORDIC_STEPS(CORDIC_STEPS)) u_useq (
    .clk  (clk),
    .rst_n(rst_n),
    .stat (stat),
    .ctrl (ctrl)
  );

  pvsr_cordic #(.MAG_BITS(MAG_BITS)) u_cordic (
    .clk      (clk),
    .ctrl     (ctrl),
    .pre_prod (pre_r),
    .angle_in (ang_r),
    .vec_x    (acc_x_r),
    .vec_y    (acc_y_r),
    .rot_x    (rot_x),
    .rot_y    (rot_y),
    .vec_angle(vec_angle)
  );

  pvsr_root u_root (
    .clk (clk),
    .ctrl(ctrl),
    .din (mul_r),
    .root(root)
  );

  // held low through reset
  assign in_ready  = ctrl.take_in && rst_n;
  assign accept    = in_valid && in_ready;
  assign out_busy  = out_valid_r && !out_ready;
  assign emit_fire = ctrl.emit && !out_busy;
  assign stat      = '{in_valid: in_valid, last: last_r, out_busy: out_busy};

  // input word latch and gain prescale product
  always_ff @(posedge clk) begin
    if (accept) begin
      pre_r  <= PRE_W'(in_data.force_magnitude) * PRE_W'(GAIN_Q30);
      ang_r  <= in_data.force_angle;
      last_r <= in_data.last_force;
    end
  end

  // saturating running sums
  always_comb begin
    sum_x     = SUM_W'(acc_x_r) + SUM_W'(rot_x);
    sum_y     = SUM_W'(acc_y_r) + SUM_W'(rot_y);
    acc_x_nxt = acc_x_r;
    acc_y_nxt = acc_y_r;
    ovf_nxt   = ovf_r;
    if (emit_fire) begin
      acc_x_nxt = '0;
      acc_y_nxt = '0;
      ovf_nxt   = 1'b0;
    end else if (ctrl.accum) begin
      if (sum_x > SAT_HI) begin
        acc_x_nxt = SAT_HI[31:0];
        ovf_nxt   = 1'b1;
      end else if (sum_x < SAT_LO) begin
        acc_x_nxt = SAT_LO[31:0];
        ovf_nxt   = 1'b1;
      end else begin
        acc_x_nxt = sum_x[31:0];
      end
      if (sum_y > SAT_HI) begin
        acc_y_nxt = SAT_HI[31:0];
        ovf_nxt   = 1'b1;
      end else if (sum_y < SAT_LO) begin
        acc_y_nxt = SAT_LO[31:0];
        ovf_nxt   = 1'b1;
      end else begin
        acc_y_nxt = sum_y[31:0];
      end
    end
  end

  // one shared squarer for the root input
  always_comb begin
    mul_src = (ctrl.mul_op == MUL_SQ_X) ? acc_x_r : acc_y_r;
    sq      = mul_src * mul_src;
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_op != MUL_NOP) begin
      mul_r <= ROOT_W'(sq);
    end
  end

  always_comb begin
    out_nxt.total_x             = acc_x_r;
    out_nxt.total_y             = acc_y_r;
    out_nxt.resultant_magnitude = root;
    out_nxt.resultant_angle     = vec_angle;
    out_nxt.sum_overflow        = ovf_r;
    if (emit_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_x_r     <= '0;
      acc_y_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_x_r     <= acc_x_nxt;
      acc_y_r     <= acc_y_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`include "assert_macros.svh"

  `PVSR_ASSERT(a_emit_clears, emit_fire |=> out_valid && acc_x_r == '0 && acc_y_r == '0 && !ovf_r, "sums not cleared after result")
  `PVSR_ASSERT(a_one_word, (in_valid && in_ready) |=> !in_ready, "second word taken while busy")
  `PVSR_ASSERT(a_out_from_emit, $rose(out_valid) |-> $past(ctrl.emit), "result shown without emit step")
  `PVSR_NEVER(a_no_take_on_emit, in_ready && ctrl.emit, "input taken during emit step")

endmodule
